### rtl/core/mcf_pkg.sv
`timescale 1ns / 1ps

package mcf_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hA5;
	localparam logic [7:0] DATA_ONE  = 8'hFF;
	localparam logic [3:0] COUNT_CAP = 4'd8;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_RX    = 2'd2;
	localparam logic [1:0] CMD_END   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NONE     = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_CHKSUM   = 2'd3;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam int FRAME_MAX = 5;

	// one queued job: a transmit frame of len bytes, or a single report
	typedef struct packed {
		logic                        is_report;
		logic [2:0]                  len;
		logic [FRAME_MAX-1:0][7:0]   bytes;
		logic [31:0]                 value;
		logic [1:0]                  status;
	} job_t;

endpackage

### rtl/core/meter_command_framer_reply_checker_unit.sv
`timescale 1ns / 1ps

// Command framer and reply checker, master side of a meter's serial register link.
// Input channel (in_valid / in_stall): cmd 0 write frame, 1 read request,
// 2 reply byte, 3 reply window ended; reg_addr, write_data, rx_byte alongside.
// Output channel (out_valid / out_stall): one transaction per transmit byte
// (out_kind 0, tx_byte, frame_last on the frame's final byte) or one read report
// (out_kind 1, read_value, read_status, frame_last set).
// The first result of an item passes through the job queue and the output register.
// Throughput: the output register delivers one result per cycle unless out_stall
// holds it; a write frame is 2, 4 or 5 transmit bytes, a read request 2, a report 1;
// reply bytes produce no result. The input takes any item, reply bytes included, one
// per cycle while the two-entry job queue between front and back has room; in_stall is
// high exactly when that queue is full.
// A stalled output holds its result; the back end and queue fill, then the
// input stalls. Reset clears the reply count and captured bytes, sets the running
// checksum to the header byte, empties the queue and drops out_valid.
module meter_command_framer_reply_checker_unit
	import mcf_pkg::*;
#(
	parameter int MAX_REPLY_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  reg_addr,
	input  logic [15:0] write_data,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [7:0]  tx_byte,
	output logic        frame_last,
	output logic [31:0] read_value,
	output logic [1:0]  read_status
);

	logic full;
	logic push;
	logic pop;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	assign in_stall = full;

	mcf_front #(
		.MAX_REPLY_BYTES(MAX_REPLY_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_valid && !full),
		.cmd(cmd),
		.reg_addr(reg_addr),
		.write_data(write_data),
		.rx_byte(rx_byte),
		.push(push),
		.job(push_job)
	);

	mcf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.full(full),
		.head_valid(head_valid),
		.head_job(head_job)
	);

	mcf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_job(head_job),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_kind(out_kind),
		.tx_byte(tx_byte),
		.frame_last(frame_last),
		.read_value(read_value),
		.read_status(read_status)
	);

endmodule

### rtl/core/mcf_front.sv
`timescale 1ns / 1ps

module mcf_front
	import mcf_pkg::*;
#(
	parameter int MAX_REPLY_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  cmd,
	input  logic [7:0]  reg_addr,
	input  logic [15:0] write_data,
	input  logic [7:0]  rx_byte,
	output logic        push,
	output job_t        job
);

	localparam logic [3:0] MAX_CNT = 4'(MAX_REPLY_BYTES);

	logic [3:0]  count_q;
	// sum_q starts at header plus pending register; it and value_q cover all
	// stored bytes but the newest, held in last_q
	logic [7:0]  sum_q;
	logic [31:0] value_q;
	logic [7:0]  last_q;

	logic [7:0]  chk_w;
	logic [7:0]  chk_r;

	assign push = accept && (cmd != CMD_RX);

	always_comb begin
		job = '0;
		chk_w = 8'h00;
		chk_r = ~sum_q;
		case (cmd)
			CMD_WRITE: begin
				job.len = 3'd2;
				job.bytes[0] = HDR_BYTE;
				job.bytes[1] = reg_addr;
				if (write_data != 16'h0000) begin
					if (write_data < {8'h00, DATA_ONE}) begin
						chk_w = ~(HDR_BYTE + reg_addr + write_data[7:0]);
						job.len = 3'd4;
						job.bytes[2] = write_data[7:0];
						job.bytes[3] = chk_w;
					end else begin
						chk_w = ~(HDR_BYTE + reg_addr + write_data[15:8] + write_data[7:0]);
						job.len = 3'd5;
						job.bytes[2] = write_data[15:8];
						job.bytes[3] = write_data[7:0];
						job.bytes[4] = chk_w;
					end
				end
			end
			CMD_READ: begin
				job.len = 3'd2;
				job.bytes[0] = HDR_BYTE;
				job.bytes[1] = reg_addr;
			end
			CMD_END: begin
				job.is_report = 1'b1;
				job.len = 3'd1;
				if (count_q == 4'd0) begin
					job.status = ST_NONE;
				end else if (count_q > MAX_CNT) begin
					job.status = ST_OVERFLOW;
				end else if (chk_r != last_q) begin
					job.status = ST_CHKSUM;
				end else begin
					job.status = ST_OK;
					job.value = value_q;
				end
			end
			default: begin
				job = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
			sum_q <= HDR_BYTE;
			value_q <= 32'h0;
			last_q <= 8'h00;
		end else if (accept) begin
			if (cmd == CMD_READ) begin
				count_q <= 4'd0;
				sum_q <= HDR_BYTE + reg_addr;
				value_q <= 32'h0;
				last_q <= 8'h00;
			end else if (cmd == CMD_RX && count_q < COUNT_CAP) begin
				count_q <= count_q + 4'd1;
				if (count_q < MAX_CNT) begin
					last_q <= rx_byte;
					if (count_q != 4'd0) begin
						sum_q <= sum_q + last_q;
						value_q <= {value_q[23:0], last_q};
					end
				end
			end
		end
	end

endmodule

### rtl/core/mcf_queue.sv
`timescale 1ns / 1ps

module mcf_queue
	import mcf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/mcf_back.sv
`timescale 1ns / 1ps

module mcf_back
	import mcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  job_t        head_job,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [7:0]  tx_byte,
	output logic        frame_last,
	output logic [31:0] read_value,
	output logic [1:0]  read_status
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic       load;
	logic       last_w;
	logic [7:0] byte_w;

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign last_w = (idx_q == head_job.len - 3'd1);
	assign pop = load && last_w;
	assign out_valid = out_valid_q;

	always_comb begin
		case (idx_q)
			3'd0:    byte_w = head_job.bytes[0];
			3'd1:    byte_w = head_job.bytes[1];
			3'd2:    byte_w = head_job.bytes[2];
			3'd3:    byte_w = head_job.bytes[3];
			default: byte_w = head_job.bytes[4];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q <= last_w ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind <= head_job.is_report ? KIND_REPORT : KIND_TX;
			tx_byte <= head_job.is_report ? 8'h00 : byte_w;
			frame_last <= last_w;
			read_value <= head_job.is_report ? head_job.value : 32'h0;
			read_status <= head_job.is_report ? head_job.status : ST_OK;
		end
	end

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind == KIND_REPORT |-> frame_last && tx_byte == 8'h00)
		else $error("report not marked last");

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head_job.len)
		else $error("byte index beyond frame length");

	a_idx_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 3'd0)
		else $error("byte index not rewound after frame");

endmodule

### tb/mcf_link_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the framer, predicts each result and compares.
module mcf_link_checker
	import mcf_pkg::*;
#(
	parameter int REPLY_DEPTH = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  reg_addr,
	input  logic [15:0] write_data,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        out_kind,
	input  logic [7:0]  tx_byte,
	input  logic        frame_last,
	input  logic [31:0] read_value,
	input  logic [1:0]  read_status,
	output int          fail_count,
	output int          outstanding,
	output int          tx_seen,
	output int          ok_seen,
	output int          none_seen,
	output int          overflow_seen,
	output int          badsum_seen
);

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx;
		logic        last;
		logic [31:0] value;
		logic [1:0]  status;
	} link_result_t;

	link_result_t due_results[$];

	logic [7:0] held_reg;
	logic [3:0] held_count;
	logic [7:0] held_bytes [0:7];

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		fail_count++;
	endtask

	task automatic push_tx(input logic [7:0] b, input logic last);
		link_result_t r;
		r.kind   = KIND_TX;
		r.tx     = b;
		r.last   = last;
		r.value  = '0;
		r.status = ST_OK;
		due_results.push_back(r);
	endtask

	task automatic frame_bytes(input logic [7:0] ra, input logic [15:0] wd);
		logic [7:0] fb [0:4];
		logic [7:0] sum;
		int len;
		int i;
		fb[0] = HDR_BYTE;
		fb[1] = ra;
		len = 2;
		if (wd != 16'd0) begin
			if (wd < {8'h00, DATA_ONE}) begin
				fb[2] = wd[7:0];
				len = 3;
			end else begin
				fb[2] = wd[15:8];
				fb[3] = wd[7:0];
				len = 4;
			end
			sum = '0;
			for (i = 0; i < len; i++)
				sum = sum + fb[i];
			fb[len] = ~sum;
			len++;
		end
		for (i = 0; i < len; i++)
			push_tx(fb[i], i == len - 1);
	endtask

	task automatic reply_report();
		link_result_t r;
		logic [7:0] sum;
		int n;
		int i;
		n = held_count;
		r.kind  = KIND_REPORT;
		r.tx    = '0;
		r.last  = 1'b1;
		r.value = '0;
		if (n == 0) begin
			r.status = ST_NONE;
		end else if (n > REPLY_DEPTH) begin
			r.status = ST_OVERFLOW;
		end else begin
			sum = HDR_BYTE + held_reg;
			for (i = 0; i + 1 < n; i++) begin
				r.value = {r.value[23:0], held_bytes[i]};
				sum = sum + held_bytes[i];
			end
			// last captured byte carries the inverted sum
			if (~sum != held_bytes[n-1]) begin
				r.status = ST_CHKSUM;
				r.value  = '0;
			end else begin
				r.status = ST_OK;
			end
		end
		due_results.push_back(r);
	endtask

	task automatic predict_command();
		int i;
		case (cmd)
			CMD_WRITE: frame_bytes(reg_addr, write_data);
			CMD_READ: begin
				held_reg   = reg_addr;
				held_count = '0;
				for (i = 0; i < 8; i++)
					held_bytes[i] = '0;
				frame_bytes(reg_addr, 16'd0);
			end
			CMD_RX: begin
				if (held_count < COUNT_CAP) begin
					if (held_count < REPLY_DEPTH)
						held_bytes[held_count[2:0]] = rx_byte;
					held_count = held_count + 4'd1;
				end
			end
			default: reply_report();
		endcase
	endtask

	task automatic check_result();
		link_result_t w;
		if (due_results.size() == 0) begin
			flag_mismatch("unexpected result, tx_byte", 32'h0, {24'h0, tx_byte});
		end else begin
			w = due_results.pop_front();
			if (out_kind !== w.kind)
				flag_mismatch("out_kind", {31'h0, w.kind}, {31'h0, out_kind});
			if (tx_byte !== w.tx)
				flag_mismatch("tx_byte", {24'h0, w.tx}, {24'h0, tx_byte});
			if (frame_last !== w.last)
				flag_mismatch("frame_last", {31'h0, w.last}, {31'h0, frame_last});
			if (read_value !== w.value)
				flag_mismatch("read_value", w.value, read_value);
			if (read_status !== w.status)
				flag_mismatch("read_status", {30'h0, w.status}, {30'h0, read_status});
			if (w.kind == KIND_TX)
				tx_seen++;
			else case (w.status)
				ST_OK:       ok_seen++;
				ST_NONE:     none_seen++;
				ST_OVERFLOW: overflow_seen++;
				default:     badsum_seen++;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_reg      = '0;
			held_count    = '0;
			for (int i = 0; i < 8; i++)
				held_bytes[i] = '0;
			due_results.delete();
			fail_count    = 0;
			tx_seen       = 0;
			ok_seen       = 0;
			none_seen     = 0;
			overflow_seen = 0;
			badsum_seen   = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_command();
			if (out_valid && !out_stall)
				check_result();
			outstanding <= due_results.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import mcf_pkg::*;

	localparam int REPLY_DEPTH    = 5;
	localparam int RUN_ITEMS      = 450;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_WRITE;
	logic [7:0]  reg_addr = '0;
	logic [15:0] write_data = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        out_kind;
	logic [7:0]  tx_byte;
	logic        frame_last;
	logic [31:0] read_value;
	logic [1:0]  read_status;

	int fail_count, outstanding;
	int tx_seen, ok_seen, none_seen, overflow_seen, badsum_seen;
	int items_sent = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	int stall_pick;
	logic sender_quiet = 1'b0;

	always #2 clk = ~clk;

	meter_command_framer_reply_checker_unit #(
		.MAX_REPLY_BYTES(REPLY_DEPTH)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .reg_addr(reg_addr), .write_data(write_data), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_kind(out_kind), .tx_byte(tx_byte), .frame_last(frame_last),
		.read_value(read_value), .read_status(read_status)
	);

	mcf_link_checker #(
		.REPLY_DEPTH(REPLY_DEPTH)
	) link_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .reg_addr(reg_addr), .write_data(write_data), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_kind(out_kind), .tx_byte(tx_byte), .frame_last(frame_last),
		.read_value(read_value), .read_status(read_status),
		.fail_count(fail_count), .outstanding(outstanding),
		.tx_seen(tx_seen), .ok_seen(ok_seen), .none_seen(none_seen),
		.overflow_seen(overflow_seen), .badsum_seen(badsum_seen)
	);

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 40);
	endfunction

	function automatic int sender_gap();
		if (sender_quiet || $urandom_range(0, 99) < 45)
			return 0;
		return idle_len();
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	// receiver: stall bursts, short free runs, and long stretches with no stall
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 10) begin
				out_stall  <= 1'b0;
				stall_left <= $urandom_range(30, 80);
			end else if (stall_pick < 55) begin
				out_stall  <= 1'b0;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_stall  <= 1'b1;
				stall_left <= idle_len() - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(input logic [1:0] c, input logic [7:0] ra, input logic [15:0] wd,
			input logic [7:0] rb);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		reg_addr   <= ra;
		write_data <= wd;
		rx_byte    <= rb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_write(input logic [7:0] ra, input logic [15:0] wd);
		send(CMD_WRITE, ra, wd, rnd8());
	endtask

	task automatic send_end();
		send(CMD_END, rnd8(), rnd16(), rnd8());
	endtask

	// read request, n reply bytes, reply end; a bad reply always misses the checksum
	task automatic read_transaction(input logic [7:0] ra, input int n, input logic good);
		logic [7:0] sum;
		logic [7:0] b;
		int i;
		send(CMD_READ, ra, rnd16(), rnd8());
		sum = HDR_BYTE + ra;
		for (i = 0; i < n; i++) begin
			b = rnd8();
			if (i == n - 1)
				b = good ? ~sum : ~sum ^ 8'($urandom_range(1, 255));
			sum = sum + b;
			send(CMD_RX, rnd8(), rnd16(), b);
		end
		send_end();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int pick;
		int n;
		int next_drain;
		logic [15:0] wd;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reply end with nothing captured, then a lone checksum byte with no read
		send_end();
		send(CMD_RX, rnd8(), rnd16(), 8'h5A);
		send_end();
		send_end();
		send_write(8'h00, 16'h0000);
		send_write(8'hFF, 16'h0001);
		send_write(8'h5A, 16'h00FE);
		send_write(8'h3C, 16'h00FF);
		send_write(8'hFF, 16'hFFFF);
		read_transaction(8'h10, 5, 1'b1);
		read_transaction(8'hEE, 1, 1'b0);
		// pile on past the count cap
		repeat (8) send(CMD_RX, rnd8(), rnd16(), rnd8());
		send_end();
		drain();

		next_drain = items_sent + 150;
		while (items_sent < RUN_ITEMS) begin
			if ($urandom_range(0, 29) == 0)
				sender_quiet = ~sender_quiet;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				pick = $urandom_range(0, 99);
				if (pick < 15)
					wd = 16'h0000;
				else if (pick < 40)
					wd = 16'($urandom_range(1, 254));
				else if (pick < 50)
					wd = 16'h00FF;
				else if (pick < 60)
					wd = ($urandom_range(0, 1) != 0) ? 16'h0100 : 16'hFFFF;
				else
					wd = rnd16();
				send_write(rnd8(), wd);
			end else if (pick < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					n = 0;
				else if (pick < 85)
					n = $urandom_range(1, 5);
				else
					n = $urandom_range(6, 10);
				read_transaction(rnd8(), n, $urandom_range(0, 3) != 0);
				if ($urandom_range(0, 5) == 0)
					send_end();
			end else begin
				send(2'($urandom), rnd8(), rnd16(), rnd8());
			end
			if (items_sent >= next_drain) begin
				drain();
				next_drain = items_sent + 150;
			end
		end

		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d commands: %0d transmit bytes; reports ok %0d, empty %0d,",
			items_sent, tx_seen, ok_seen, none_seen);
		$display("overflow %0d, bad checksum %0d; %0d mismatches",
			overflow_seen, badsum_seen, fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
